// ===== rtl/bfha_pkg.sv =====
// Shared types and constants of the best-fit heap allocator.
`default_nettype none
package bfha_pkg;

   localparam int MAX_FREE_BLOCKS_DEFAULT = 16;
   localparam logic [31:0] HEAP_TOP_RESET = 32'd65536;
   localparam logic [31:0] HDR_BYTES = 32'd4;
   localparam logic [31:0] DESC_BYTES = 32'd8;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_NO_FIT = 2'd1;
   localparam logic [1:0] ST_BAD_FREE = 2'd2;
   localparam logic [1:0] ST_FULL = 2'd3;

   localparam logic [0:0] CSR_HEAP_BASE = 1'd0;
   localparam logic [0:0] CSR_HEAP_TOP = 1'd1;

   typedef struct packed {
      logic [31:0] start;
      logic [31:0] len;
   } entry_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_ROT,
      CELL_SETLEN,
      CELL_SET,
      CELL_REMOVE,
      CELL_INSERT
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      entry_type   data;
   } cell_cmd_type;

endpackage
`default_nettype wire

// ===== rtl/bfha_cell.sv =====
// One slot of the free-block table, linked to its two neighbours.
`default_nettype none
module bfha_cell #(
   parameter int IW = 4,
   parameter int INDEX = 0,
   parameter bit LAST = 1'b0
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire bfha_pkg::cell_cmd_type cmd,
   input  wire logic [IW-1:0]         cmd_k,
   input  wire bfha_pkg::entry_type   left_in,
   input  wire bfha_pkg::entry_type   right_in,
   output bfha_pkg::entry_type        entry_out
);

   localparam logic [IW-1:0] IDX = IW'(INDEX);

   bfha_pkg::entry_type entry_ff, entry_in;

   always_comb begin
      entry_in = entry_ff;
      unique case (cmd.op)
         bfha_pkg::CELL_ROT: entry_in = right_in;
         bfha_pkg::CELL_SETLEN: begin
            if (IDX == cmd_k) entry_in.len = cmd.data.len;
         end
         bfha_pkg::CELL_SET: begin
            if (IDX == cmd_k) entry_in = cmd.data;
         end
         bfha_pkg::CELL_REMOVE: begin
            if (IDX >= cmd_k && !LAST) entry_in = right_in;
         end
         bfha_pkg::CELL_INSERT: begin
            if (IDX > cmd_k) entry_in = left_in;
            else if (IDX == cmd_k) entry_in = cmd.data;
         end
         default: entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.start <= '0;
         entry_ff.len <= (INDEX == 0) ? bfha_pkg::HEAP_TOP_RESET : 32'd0;
      end else begin
         entry_ff <= entry_in;
      end
   end

   assign entry_out = entry_ff;

endmodule
`default_nettype wire

// ===== rtl/bfha_ctrl.sv =====
// Sequencer: handshakes, table scan, decision and table update.
`default_nettype none
module bfha_ctrl #(
   parameter int N = bfha_pkg::MAX_FREE_BLOCKS_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [87:0]            req_tdata,
   input  wire logic [0:0]             req_tuser,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [63:0]                 rsp_tdata,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [0:0]             csr_index,
   input  wire logic [31:0]            csr_data,
   input  wire bfha_pkg::entry_type    head,
   output bfha_pkg::cell_cmd_type      cmd,
   output logic [$clog2(N)-1:0]        cmd_k
);

   localparam int IW = $clog2(N);
   localparam int CW = $clog2(N + 1);
   localparam logic [IW-1:0] J_LAST = IW'(N - 1);
   localparam logic [CW-1:0] COUNT_MAX = CW'(N);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_SCAN   = 5'b00010,
      S_APPLY  = 5'b00100,
      S_APPLY2 = 5'b01000,
      S_DONE   = 5'b10000
   } state_type;

   typedef enum logic [2:0] {
      FC_NONE,
      FC_BAD,
      FC_PREV,
      FC_FOLLOW,
      FC_INSERT
   } fcase_type;

   state_type state_ff, state_in;
   fcase_type fcase_ff, fcase_in;
   logic [CW-1:0] count_ff, count_in;
   logic [IW-1:0] j_ff, j_in;
   logic [31:0] bottom_ff, bottom_in, top_ff, top_in;
   logic act_ff, act_in;
   logic [24:0] total_ff, total_in, size_ff, size_in;
   logic [31:0] addr_ff, addr_in, hdr_ff, hdr_in;
   logic found_ff, found_in, decided_ff, decided_in, merge_next_ff, merge_next_in;
   logic [IW-1:0] best_idx_ff, best_idx_in, dec_idx_ff, dec_idx_in;
   logic [31:0] best_start_ff, best_start_in, best_len_ff, best_len_in;
   logic [31:0] new_start_ff, new_start_in, new_len_ff, new_len_in;
   logic [1:0] res_status_ff, res_status_in;
   logic [31:0] res_uaddr_ff, res_uaddr_in;
   logic [24:0] res_hsize_ff, res_hsize_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [63:0] rsp_data_ff, rsp_data_in;

   logic [24:0] rounded;
   logic [31:0] size32, total32, need, s, l, head_end, rem;
   logic active, pre_bad;

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

   always_comb begin
      state_in = state_ff;
      fcase_in = fcase_ff;
      count_in = count_ff;
      j_in = j_ff;
      bottom_in = bottom_ff;
      top_in = top_ff;
      act_in = act_ff;
      total_in = total_ff;
      size_in = size_ff;
      addr_in = addr_ff;
      hdr_in = hdr_ff;
      found_in = found_ff;
      decided_in = decided_ff;
      merge_next_in = merge_next_ff;
      best_idx_in = best_idx_ff;
      dec_idx_in = dec_idx_ff;
      best_start_in = best_start_ff;
      best_len_in = best_len_ff;
      new_start_in = new_start_ff;
      new_len_in = new_len_ff;
      res_status_in = res_status_ff;
      res_uaddr_in = res_uaddr_ff;
      res_hsize_in = res_hsize_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      cmd.op = bfha_pkg::CELL_HOLD;
      cmd.data = head;
      cmd_k = '0;

      rounded = ({1'b0, req_tdata[23:0]} + 25'd3) & ~25'd3;
      size32 = {7'b0, size_ff};
      total32 = {7'b0, total_ff};
      need = total32 + bfha_pkg::DESC_BYTES;
      s = head.start;
      l = head.len;
      head_end = s + l;
      rem = best_len_ff - total32;
      active = CW'(j_ff) < count_ff;
      pre_bad = (j_ff == '0) && ((addr_ff == '0) || (addr_ff <= s));

      if (csr_valid) begin
         if (csr_index == bfha_pkg::CSR_HEAP_BASE) begin
            bottom_in = csr_data & ~32'd3;
            cmd.op = bfha_pkg::CELL_SET;
            cmd.data.start = bottom_in;
            cmd.data.len = top_ff - bottom_in;
            cmd_k = '0;
            count_in = CW'(1);
         end else begin
            top_in = csr_data;
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               act_in = req_tuser[0];
               total_in = rounded + 25'd4;
               addr_in = req_tdata[55:24];
               hdr_in = req_tdata[55:24] - bfha_pkg::HDR_BYTES;
               size_in = req_tdata[80:56];
               found_in = 1'b0;
               decided_in = 1'b0;
               merge_next_in = 1'b0;
               fcase_in = FC_NONE;
               j_in = '0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.op = bfha_pkg::CELL_ROT;
            if (!act_ff) begin
               if (active && l >= need && (!found_ff || best_len_ff > l)) begin
                  found_in = 1'b1;
                  best_idx_in = j_ff;
                  best_start_in = s;
                  best_len_in = l;
               end
            end else begin
               if (active && !decided_ff) begin
                  decided_in = 1'b1;
                  dec_idx_in = j_ff;
                  if (pre_bad) begin
                     fcase_in = FC_BAD;
                  end else if (hdr_ff == head_end) begin
                     fcase_in = FC_PREV;
                     new_len_in = l + size32;
                  end else if (hdr_ff < s) begin
                     if (j_ff == '0) fcase_in = FC_BAD;
                     else if (hdr_ff + size32 == s) begin
                        fcase_in = FC_FOLLOW;
                        new_start_in = hdr_ff;
                        new_len_in = l + (s - hdr_ff);
                     end else begin
                        fcase_in = FC_INSERT;
                     end
                  end else begin
                     decided_in = 1'b0;
                  end
               end
               // The block after a merged one may join as well.
               if (active && decided_ff && fcase_ff == FC_PREV
                   && {1'b0, j_ff} == {1'b0, dec_idx_ff} + 1'b1
                   && s == hdr_ff + size32) begin
                  merge_next_in = 1'b1;
                  new_len_in = new_len_ff + l;
               end
            end
            if (j_ff == J_LAST) begin
               j_in = '0;
               state_in = S_APPLY;
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         S_APPLY: begin
            res_status_in = bfha_pkg::ST_OK;
            res_uaddr_in = '0;
            res_hsize_in = '0;
            state_in = S_DONE;
            if (!act_ff) begin
               if (found_ff) begin
                  cmd.op = bfha_pkg::CELL_SETLEN;
                  cmd_k = best_idx_ff;
                  cmd.data.len = rem;
                  res_uaddr_in = best_start_ff + rem + bfha_pkg::HDR_BYTES;
                  res_hsize_in = total_ff;
               end else begin
                  res_status_in = bfha_pkg::ST_NO_FIT;
               end
            end else begin
               case (fcase_ff)
                  FC_BAD: res_status_in = bfha_pkg::ST_BAD_FREE;
                  FC_PREV: begin
                     cmd.op = bfha_pkg::CELL_SETLEN;
                     cmd_k = dec_idx_ff;
                     cmd.data.len = new_len_ff;
                     if (merge_next_ff) state_in = S_APPLY2;
                  end
                  FC_FOLLOW: begin
                     cmd.op = bfha_pkg::CELL_SET;
                     cmd_k = dec_idx_ff;
                     cmd.data.start = new_start_ff;
                     cmd.data.len = new_len_ff;
                  end
                  default: begin
                     if (fcase_ff == FC_NONE && count_ff == '0) begin
                        res_status_in = bfha_pkg::ST_BAD_FREE;
                     end else if (count_ff >= COUNT_MAX) begin
                        res_status_in = bfha_pkg::ST_FULL;
                     end else begin
                        cmd.op = bfha_pkg::CELL_INSERT;
                        cmd_k = (fcase_ff == FC_NONE) ? IW'(count_ff) : dec_idx_ff;
                        cmd.data.start = hdr_ff;
                        cmd.data.len = size32;
                        count_in = count_ff + 1'b1;
                     end
                  end
               endcase
            end
         end
         S_APPLY2: begin
            cmd.op = bfha_pkg::CELL_REMOVE;
            cmd_k = dec_idx_ff + 1'b1;
            count_in = count_ff - 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = {5'b0, res_hsize_ff, res_uaddr_ff, res_status_ff};
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fcase_ff <= FC_NONE;
         count_ff <= CW'(1);
         j_ff <= '0;
         bottom_ff <= '0;
         top_ff <= bfha_pkg::HEAP_TOP_RESET;
         found_ff <= 1'b0;
         decided_ff <= 1'b0;
         merge_next_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fcase_ff <= fcase_in;
         count_ff <= count_in;
         j_ff <= j_in;
         bottom_ff <= bottom_in;
         top_ff <= top_in;
         found_ff <= found_in;
         decided_ff <= decided_in;
         merge_next_ff <= merge_next_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff <= act_in;
      total_ff <= total_in;
      size_ff <= size_in;
      addr_ff <= addr_in;
      hdr_ff <= hdr_in;
      best_idx_ff <= best_idx_in;
      dec_idx_ff <= dec_idx_in;
      best_start_ff <= best_start_in;
      best_len_ff <= best_len_in;
      new_start_ff <= new_start_in;
      new_len_ff <= new_len_in;
      res_status_ff <= res_status_in;
      res_uaddr_ff <= res_uaddr_in;
      res_hsize_ff <= res_hsize_in;
      rsp_data_ff <= rsp_data_in;
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_MAX)
      else $error("free table count beyond capacity");

   a_accept_starts_scan: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == S_SCAN && j_ff == '0))
      else $error("accepted transfer did not start a scan");

   a_counter_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_SCAN) |-> (j_ff == '0))
      else $error("scan counter not at rest outside a scan");

   a_remove_shrinks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_APPLY2 && !csr_valid) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("merge with following block did not drop an entry");

endmodule
`default_nettype wire

// ===== rtl/best_fit_heap_allocator.sv =====
// Top level of the best-fit heap allocator: sequencer and row of table cells.
//
// Usage: an operation arrives as one transfer on the req_ channel. req_tuser
// selects allocate (0) or free (1); req_tdata carries the request size, the
// user address and the header size of a block being freed. Every operation
// gives exactly one result transfer on the rsp_ channel with a status, the
// user address of an allocation and the total size to store in its header.
// The free table lives in a row of MAX_FREE_BLOCKS cells. An operation first
// rotates the whole row once past the sequencer, one entry per cycle, which
// brings the table back to its place; it then updates the row in S_APPLY and,
// when a freed block joins both neighbours, in S_APPLY2 as well (write a slot,
// or shift the cells for an insert or a removal). The result is then loaded
// into an output register from S_DONE, and the sequencer returns to S_IDLE to
// take the next operation. A finished result waits in that output register
// while the next operation is accepted. If the receiver stalls, the
// sequencer holds its next result until that register is free.
// After reset the table holds one block from address 0 of 65536 bytes.
// Writing the heap base register over csr_ reloads the table as one block;
// csr_ready is always high; writes are only to be made by the user while no
// operation is in progress, which the block itself does not enforce.
`default_nettype none
module best_fit_heap_allocator #(
   parameter int MAX_FREE_BLOCKS = bfha_pkg::MAX_FREE_BLOCKS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // request_size [23:0], block_address [55:24], block_size [80:56]
   input  wire logic [87:0] req_tdata,
   // action [0]
   input  wire logic [0:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // status [1:0], user_address [33:2], header_size [58:34]
   output logic [63:0]      rsp_tdata,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [0:0]  csr_index,
   input  wire logic [31:0] csr_data
);

   localparam int N = MAX_FREE_BLOCKS;
   localparam int IW = $clog2(N);

   // Slot contents of every cell; slot 0 is the head seen by the sequencer.
   bfha_pkg::entry_type entries [N];
   bfha_pkg::cell_cmd_type cmd;
   logic [IW-1:0] cmd_k;

   bfha_ctrl #(.N(N)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .head       (entries[0]),
      .cmd        (cmd),
      .cmd_k      (cmd_k)
   );

   // Each cell takes from its right neighbour on a rotation or removal and
   // from its left neighbour on an insert; the row closes into a ring.
   for (genvar g = 0; g < N; g++) begin : g_cell
      bfha_cell #(
         .IW    (IW),
         .INDEX (g),
         .LAST  (g == N - 1)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .cmd_k     (cmd_k),
         .left_in   (entries[(g + N - 1) % N]),
         .right_in  (entries[(g + 1) % N]),
         .entry_out (entries[g])
      );
   end

endmodule
`default_nettype wire
